FILE: rtl/core/qpd_pkg.sv
// Shared types, character constants and hex helpers for the quoted-printable decoder.
package qpd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } entry_t;

    function automatic logic hex_valid(input logic [7:0] c);
        hex_valid = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                    (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
        end
        hex_val = d[3:0];
    endfunction

endpackage

FILE: rtl/core/qpd_front.sv
// Front end: accepts raw bytes, tracks header and escape state, and forms result groups.
module qpd_front
    import qpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output entry_t     entry
);

    logic       in_body_reg, in_body_next;
    logic       prev_lf_reg, prev_lf_next;
    logic       in_esc_reg, in_esc_next;
    logic [1:0] pos_reg, pos_next;
    logic [7:0] held_reg, held_next;
    logic       cr_reg, cr_next;
    logic       blank_reg, blank_next;

    always_comb
    begin
        in_body_next = in_body_reg;
        prev_lf_next = prev_lf_reg;
        in_esc_next  = in_esc_reg;
        pos_next     = pos_reg;
        held_next    = held_reg;
        cr_next      = cr_reg;
        blank_next   = blank_reg;
        entry        = '0;

        if (!in_body_reg)
        begin
            entry.cnt = 2'd1;
            entry.b0  = in_byte;
            if (in_byte != CH_CR)
            begin
                if (prev_lf_reg && in_byte == CH_LF)
                begin
                    in_body_next = 1'b1;
                end
                prev_lf_next = (in_byte == CH_LF);
            end
        end
        else if (!in_esc_reg)
        begin
            if (in_byte == CH_EQ)
            begin
                in_esc_next = 1'b1;
                pos_next    = POS_FIRST;
                cr_next     = 1'b0;
                blank_next  = 1'b0;
            end
            else
            begin
                entry.cnt = 2'd1;
                entry.b0  = in_byte;
            end
        end
        else
        begin
            unique case (pos_reg)
                POS_FIRST:
                begin
                    if (in_byte == CH_EQ)
                    begin
                        entry.cnt = 2'd1;
                        entry.b0  = CH_EQ;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        in_esc_next = 1'b0;
                    end
                    else if (in_byte == CH_CR)
                    begin
                        held_next = in_byte;
                        cr_next   = 1'b1;
                        pos_next  = POS_SECOND;
                    end
                    else if (in_byte == CH_SP)
                    begin
                        held_next  = in_byte;
                        blank_next = 1'b1;
                        pos_next   = POS_SECOND;
                    end
                    else if (hex_valid(in_byte))
                    begin
                        held_next = in_byte;
                        pos_next  = POS_SECOND;
                    end
                    else
                    begin
                        entry.cnt   = 2'd2;
                        entry.b0    = CH_EQ;
                        entry.b1    = in_byte;
                        in_esc_next = 1'b0;
                    end
                end
                POS_SECOND:
                begin
                    if (in_byte == CH_EQ)
                    begin
                        if (!cr_reg)
                        begin
                            entry.cnt = 2'd2;
                            entry.b0  = CH_EQ;
                            entry.b1  = held_reg;
                        end
                        pos_next   = POS_FIRST;
                        cr_next    = 1'b0;
                        blank_next = 1'b0;
                    end
                    else if (cr_reg)
                    begin
                        if (in_byte != CH_LF)
                        begin
                            entry.cnt = 2'd1;
                            entry.b0  = in_byte;
                        end
                        in_esc_next = 1'b0;
                        pos_next    = POS_FIRST;
                        cr_next     = 1'b0;
                        blank_next  = 1'b0;
                    end
                    else if (blank_reg)
                    begin
                        if (in_byte == CH_LF)
                        begin
                            in_esc_next = 1'b0;
                            pos_next    = POS_FIRST;
                            blank_next  = 1'b0;
                        end
                        else if (in_byte == CH_CR)
                        begin
                            cr_next  = 1'b1;
                            pos_next = POS_THIRD;
                        end
                        else
                        begin
                            entry.cnt   = 2'd3;
                            entry.b0    = CH_EQ;
                            entry.b1    = CH_SP;
                            entry.b2    = in_byte;
                            in_esc_next = 1'b0;
                            pos_next    = POS_FIRST;
                            blank_next  = 1'b0;
                        end
                    end
                    else if (hex_valid(in_byte))
                    begin
                        entry.cnt   = 2'd1;
                        entry.b0    = {hex_val(held_reg), hex_val(in_byte)};
                        in_esc_next = 1'b0;
                        pos_next    = POS_FIRST;
                    end
                    else
                    begin
                        entry.cnt   = 2'd3;
                        entry.b0    = CH_EQ;
                        entry.b1    = held_reg;
                        entry.b2    = in_byte;
                        in_esc_next = 1'b0;
                        pos_next    = POS_FIRST;
                    end
                end
                default:
                begin
                    if (in_byte == CH_EQ)
                    begin
                        pos_next   = POS_FIRST;
                        cr_next    = 1'b0;
                        blank_next = 1'b0;
                    end
                    else
                    begin
                        if (in_byte != CH_LF)
                        begin
                            entry.cnt = 2'd1;
                            entry.b0  = in_byte;
                        end
                        in_esc_next = 1'b0;
                        pos_next    = POS_FIRST;
                        cr_next     = 1'b0;
                        blank_next  = 1'b0;
                    end
                end
            endcase
        end
    end

    assign push = accept && (entry.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg <= 1'b0;
            prev_lf_reg <= 1'b0;
            in_esc_reg  <= 1'b0;
            pos_reg     <= POS_FIRST;
            held_reg    <= 8'h00;
            cr_reg      <= 1'b0;
            blank_reg   <= 1'b0;
        end
        else if (accept)
        begin
            in_body_reg <= in_body_next;
            prev_lf_reg <= prev_lf_next;
            in_esc_reg  <= in_esc_next;
            pos_reg     <= pos_next;
            held_reg    <= held_next;
            cr_reg      <= cr_next;
            blank_reg   <= blank_next;
        end
        else if (cfg_wr_en && !cfg_wr_data)
        begin
            in_body_reg <= 1'b1;
        end
    end

endmodule

FILE: rtl/core/qpd_queue.sv
// Short queue of result groups between the front end and the output serialiser.
module qpd_queue
    import qpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    entry_t        store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/qpd_back.sv
// Back end: holds one result group and sends its bytes out one transaction at a time.
module qpd_back
    import qpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  entry_t     q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       valid_reg;
    entry_t     entry_reg;
    logic [1:0] idx_reg;
    logic       fire;
    logic       load;

    assign m_tvalid = valid_reg;
    assign m_tlast  = (idx_reg == entry_reg.cnt - 2'd1);
    assign fire     = valid_reg && m_tready;
    assign load     = !valid_reg || (fire && m_tlast);
    assign q_pop    = load && q_not_empty;

    always_comb
    begin
        case (idx_reg)
            2'd0:    m_tdata = entry_reg.b0;
            2'd1:    m_tdata = entry_reg.b1;
            default: m_tdata = entry_reg.b2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            entry_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= q_not_empty;
            idx_reg   <= 2'd0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

FILE: rtl/core/quoted_printable_decoder_unit.sv
// Top level of the quoted-printable decoder with optional mail header pass-through.
// The first output byte of an input transaction is written into the queue on acceptance and
// then loaded into the back end's output register, from which it is offered.
// Throughput: one input per cycle while the queue has room; output runs one byte per cycle,
// while m_tready is high, so an input's several bytes hold the output until all are sent.
// Reset clears the queue and decoder state and re-enables header pass-through.
module quoted_printable_decoder_unit
    import qpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // pass_header
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // out_byte
    output logic       m_tlast
);

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   full;
    logic   pop;
    logic   not_empty;
    entry_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    qpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_byte     (s_tdata),
        .push        (push),
        .entry       (push_entry)
    );

    qpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    qpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (not_empty),
        .q_head      (head),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the quoted-printable decoder unit.
module testbench;
    import qpd_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } qp_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    logic [7:0] raw_backlog[$];
    logic [7:0] step_bytes[$];
    qp_byte_t   decoded_bytes[$];

    // Decoder state as the testbench sees it.
    logic       hdr_mode = 1'b1;
    logic       body_active = 1'b0;
    logic       lf_pending = 1'b0;
    logic       esc_open = 1'b0;
    logic [1:0] esc_pos = POS_FIRST;
    logic [7:0] esc_first = 8'h00;
    logic       esc_cr = 1'b0;
    logic       esc_space = 1'b0;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic steady_in = 1'b0;
    logic steady_out = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   stall_request = 0;
    int   stall_served = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   bytes_in = 0;
    int   bytes_out = 0;
    int   header_bytes = 0;

    quoted_printable_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c - 8'h30);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return int'(c - 8'h41) + 10;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return int'(c - 8'h61) + 10;
        end
        return -1;
    endfunction

    function automatic void reopen_escape();
        esc_pos = POS_FIRST;
        esc_cr = 1'b0;
        esc_space = 1'b0;
    endfunction

    function automatic void close_escape();
        esc_open = 1'b0;
        reopen_escape();
    endfunction

    function automatic void qp_decode_step(input logic [7:0] b);
        int       hi;
        int       lo;
        qp_byte_t entry;
        step_bytes.delete();
        lo = hex_nibble(b);
        if (!body_active)
        begin
            header_bytes++;
            step_bytes.push_back(b);
            if (b != CH_CR)
            begin
                if (lf_pending && b == CH_LF)
                begin
                    body_active = 1'b1;
                end
                lf_pending = (b == CH_LF);
            end
        end
        else if (!esc_open)
        begin
            if (b == CH_EQ)
            begin
                esc_open = 1'b1;
                reopen_escape();
            end
            else
            begin
                step_bytes.push_back(b);
            end
        end
        else if (esc_pos == POS_FIRST)
        begin
            if (b == CH_EQ)
            begin
                step_bytes.push_back(CH_EQ);
            end
            else if (b == CH_LF)
            begin
                close_escape();
            end
            else if (b == CH_CR)
            begin
                esc_first = b;
                esc_cr = 1'b1;
                esc_pos = POS_SECOND;
            end
            else if (b == CH_SP)
            begin
                esc_first = b;
                esc_space = 1'b1;
                esc_pos = POS_SECOND;
            end
            else if (lo >= 0)
            begin
                esc_first = b;
                esc_pos = POS_SECOND;
            end
            else
            begin
                step_bytes.push_back(CH_EQ);
                step_bytes.push_back(b);
                close_escape();
            end
        end
        else if (esc_pos == POS_SECOND)
        begin
            if (b == CH_EQ)
            begin
                if (!esc_cr)
                begin
                    step_bytes.push_back(CH_EQ);
                    step_bytes.push_back(esc_first);
                end
                reopen_escape();
            end
            else if (esc_cr)
            begin
                if (b != CH_LF)
                begin
                    step_bytes.push_back(b);
                end
                close_escape();
            end
            else if (esc_space)
            begin
                if (b == CH_LF)
                begin
                    close_escape();
                end
                else if (b == CH_CR)
                begin
                    esc_cr = 1'b1;
                    esc_pos = POS_THIRD;
                end
                else
                begin
                    step_bytes.push_back(CH_EQ);
                    step_bytes.push_back(CH_SP);
                    step_bytes.push_back(b);
                    close_escape();
                end
            end
            else if (lo >= 0)
            begin
                hi = hex_nibble(esc_first);
                if (hi < 0)
                begin
                    hi = 0;
                end
                step_bytes.push_back({hi[3:0], lo[3:0]});
                close_escape();
            end
            else
            begin
                step_bytes.push_back(CH_EQ);
                step_bytes.push_back(esc_first);
                step_bytes.push_back(b);
                close_escape();
            end
        end
        else
        begin
            if (b == CH_EQ)
            begin
                reopen_escape();
            end
            else
            begin
                if (b != CH_LF)
                begin
                    step_bytes.push_back(b);
                end
                close_escape();
            end
        end
        foreach (step_bytes[i])
        begin
            entry.data = step_bytes[i];
            entry.last = (i == step_bytes.size() - 1);
            decoded_bytes.push_back(entry);
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("Mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    always @(posedge clk)
    begin
        qp_byte_t want;
        if (rst_n)
        begin
            cycle_count++;
            in_taken <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (cfg_wr_en)
            begin
                hdr_mode = cfg_wr_data;
                if (!cfg_wr_data)
                begin
                    body_active = 1'b1;
                end
            end
            if (s_tvalid && s_tready)
            begin
                bytes_in++;
                qp_decode_step(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                bytes_out++;
                if (decoded_bytes.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected byte %02h with last %0d",
                                            m_tdata, m_tlast));
                end
                else
                begin
                    want = decoded_bytes.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        note_mismatch($sformatf("out_byte expected %02h, got %02h",
                                                want.data, m_tdata));
                    end
                    if (m_tlast !== want.last)
                    begin
                        note_mismatch($sformatf("last expected %0d, got %0d (byte %02h)",
                                                want.last, m_tlast, want.data));
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("No transaction for %0d cycles, %0d bytes still expected",
                             IDLE_LIMIT, decoded_bytes.size());
                    $display("quoted_printable_decoder_unit regression: fail");
                    $finish;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (raw_backlog.size() > 0)
            begin
                s_tdata <= raw_backlog.pop_front();
                s_tvalid <= 1'b1;
                in_gap = steady_in ? 0 : $urandom_range(0, 5);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (stall_request != stall_served)
            begin
                stall_served = stall_request;
                hold_left = HOLD_CYCLES;
            end
            if (out_taken)
            begin
                out_gap = steady_out ? 0 : $urandom_range(0, 5);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
        begin
            return 8'(v + 32'h30);
        end
        if (v < 16)
        begin
            return 8'(v + 32'h41 - 10);
        end
        return 8'(v + 32'h61 - 16);
    endfunction

    // In directed strings '^' stands for a carriage return and '~' for a line feed.
    task automatic feed(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c == "^")
            begin
                c = CH_CR;
            end
            else if (c == "~")
            begin
                c = CH_LF;
            end
            raw_backlog.push_back(c);
        end
    endtask

    task automatic queue_chunk(input int noise_pct);
        logic [7:0] c;
        int         k;
        if ($urandom_range(0, 99) < noise_pct)
        begin
            c = 8'($urandom_range(0, 255));
            raw_backlog.push_back(c);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    k = $urandom_range(1, 3);
                    repeat (k)
                    begin
                        c = 8'($urandom_range(8'h20, 8'h7E));
                        if (c == CH_EQ)
                        begin
                            c = 8'h7E;
                        end
                        raw_backlog.push_back(c);
                    end
                end
                2, 3:
                begin
                    raw_backlog.push_back(CH_EQ);
                    raw_backlog.push_back(rand_hex());
                    raw_backlog.push_back(rand_hex());
                end
                4:
                begin
                    raw_backlog.push_back(CH_EQ);
                    k = $urandom_range(0, 3);
                    if (k >= 2)
                    begin
                        raw_backlog.push_back(CH_SP);
                    end
                    if (k == 1 || k == 3)
                    begin
                        raw_backlog.push_back(CH_CR);
                    end
                    raw_backlog.push_back(CH_LF);
                end
                5:
                begin
                    raw_backlog.push_back(CH_EQ);
                    raw_backlog.push_back(CH_EQ);
                end
                6:
                begin
                    if ($urandom_range(0, 1))
                    begin
                        raw_backlog.push_back(CH_CR);
                    end
                    raw_backlog.push_back(CH_LF);
                end
                7:
                begin
                    raw_backlog.push_back(CH_EQ);
                    raw_backlog.push_back(rand_hex());
                    c = 8'($urandom_range(0, 255));
                    raw_backlog.push_back(c);
                end
                8:
                begin
                    raw_backlog.push_back(CH_EQ);
                    c = 8'($urandom_range(0, 255));
                    raw_backlog.push_back(c);
                end
                default:
                begin
                    raw_backlog.push_back(CH_EQ);
                    k = $urandom_range(0, 4);
                    case (k)
                        0: raw_backlog.push_back(CH_SP);
                        1: raw_backlog.push_back(CH_CR);
                        2:
                        begin
                            raw_backlog.push_back(CH_SP);
                            raw_backlog.push_back(CH_CR);
                        end
                        default: raw_backlog.push_back(rand_hex());
                    endcase
                    if (k >= 3 || $urandom_range(0, 1))
                    begin
                        raw_backlog.push_back(CH_EQ);
                    end
                    else
                    begin
                        c = 8'($urandom_range(0, 255));
                        raw_backlog.push_back(c);
                    end
                end
            endcase
        end
    endtask

    task automatic load_body(input int n, input int noise_pct);
        int target;
        target = raw_backlog.size() + n;
        while (raw_backlog.size() < target)
        begin
            queue_chunk(noise_pct);
        end
    endtask

    task automatic write_pass_header(input logic value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (raw_backlog.size() != 0 || s_tvalid || decoded_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_pass_header(1'b1);

        feed("H~^~=4a=fF==~= ^~=^Q=A=G=^=9x");
        raw_backlog.push_back(8'h00);
        raw_backlog.push_back(8'hFF);
        drain();

        // The receiver stalls for a long stretch while the sender keeps offering bytes.
        stall_request++;
        load_body(45, 10);
        drain();

        write_pass_header(1'b0);
        steady_in = 1'b1;
        steady_out = 1'b1;
        load_body(45, 10);
        drain();

        write_pass_header(1'b1);
        steady_in = 1'b0;
        steady_out = 1'b0;
        load_body(45, 40);
        drain();

        $display("Checked %0d input and %0d output transactions (%0d header bytes copied),",
                 bytes_in, bytes_out, header_bytes);
        $display("over hex escapes, soft breaks, malformed escapes, both header settings and stalls.");
        if (mismatches == 0)
        begin
            $display("quoted_printable_decoder_unit regression: pass");
        end
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("quoted_printable_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule
